/* design/python_comment_string_stripper_core_defines.svh */
// ----------------------------------------------------------------------------
// Python comment/string stripper: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef PYTHON_COMMENT_STRING_STRIPPER_CORE_DEFINES_SVH
`define PYTHON_COMMENT_STRING_STRIPPER_CORE_DEFINES_SVH

// same-cycle implication
`define PCSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pcss_pkg.sv */
// ----------------------------------------------------------------------------
// pcss_pkg
// Character codes and types for the Python comment/string stripper.
// ----------------------------------------------------------------------------
package pcss_pkg;

    localparam logic [7:0] CH_SINGLE = 8'h27;
    localparam logic [7:0] CH_DOUBLE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSL    = 8'h5C;

    localparam logic [1:0] RUN_FULL  = 2'd3;
    localparam logic [1:0] BLANK_MAX = 2'd2;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_DOUBLE = 2'd2
    } doc_mode_t;

    typedef struct packed {
        logic [1:0] run;
        logic       own_open;
        logic       other_open;
        doc_mode_t  mode;
        logic       drop;
    } quote_res_t;

endpackage

/* design/python_comment_string_stripper_core.sv */
// ----------------------------------------------------------------------------
// python_comment_string_stripper_core
// Strips comments, strings and docstrings from a Python byte stream and
// squeezes blanks and blank lines.
//
// channel | dir | tdata          | tuser          | tlast
// s_*     | in  | [7:0] src byte | [0] start flag | -
// m_*     | out | [7:0] kept     | -              | -
//
// One byte per cycle while the output register is not stalled; the next-state logic is a single pass of flag logic.
// Zero or one output beat per input beat, in the cycle after acceptance.
// A single output register holds the result; input is taken whenever that
// register is empty or being drained.
// Reset clears all scan state; a start flag on a beat does the same.
// ----------------------------------------------------------------------------
module python_comment_string_stripper_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_char
    input  logic       s_tuser,   // [0] start_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] kept_char
);

    pcss_pkg::doc_mode_t mode_reg, mode_next;
    logic       sopen_reg, sopen_next;
    logic       dopen_reg, dopen_next;
    logic [1:0] srun_reg, srun_next;
    logic [1:0] drun_reg, drun_next;
    logic       esc_reg, esc_next;
    logic       cmt_reg, cmt_next;
    logic [1:0] blank_reg, blank_next;
    logic [7:0] prev_reg, prev_next;
    logic       lnl_reg, lnl_next;
    logic       ovalid_reg, ovalid_next;
    logic [7:0] odata_reg;
    logic       keep;
    logic       accept;

    function automatic pcss_pkg::quote_res_t quote_step
    (
        input logic [1:0]          run,
        input logic                own_open,
        input logic                other_open,
        input logic                prev_same,
        input pcss_pkg::doc_mode_t own_mode,
        input pcss_pkg::doc_mode_t mode,
        input logic                cmt,
        input logic                esc
    );
        pcss_pkg::quote_res_t r;
        r.run        = run;
        r.own_open   = own_open;
        r.other_open = other_open;
        r.mode       = mode;
        r.drop       = 1'b0;
        if (mode != pcss_pkg::MODE_NONE)
        begin
            if (run == pcss_pkg::RUN_FULL || prev_same)
                r.run = run - 2'd1;
            else
                r.run = pcss_pkg::RUN_FULL;
            r.mode = (r.run != 2'd0) ? own_mode : pcss_pkg::MODE_NONE;
            r.drop = (r.mode == pcss_pkg::MODE_NONE);
        end
        else
        begin
            if (run == 2'd0 && !(own_open || other_open))
                r.run = run + 2'd1;
            else if (prev_same)
                r.run = run + 2'd1;
            r.mode = (r.run == pcss_pkg::RUN_FULL) ? own_mode : pcss_pkg::MODE_NONE;
            if (r.mode != pcss_pkg::MODE_NONE)
            begin
                r.own_open   = 1'b0;
                r.other_open = 1'b0;
                r.drop       = 1'b1;
            end
            else if (!other_open && !cmt)
            begin
                if (own_open)
                begin
                    if (!esc)
                    begin
                        r.own_open = 1'b0;
                        r.drop     = 1'b1;
                    end
                end
                else
                begin
                    r.own_open = 1'b1;
                end
            end
        end
        return r;
    endfunction

    assign s_tready = !ovalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    always_comb
    begin
        pcss_pkg::quote_res_t q;
        logic                 drop;
        logic [7:0]           c;
        c    = s_tdata;
        drop = 1'b0;
        keep = 1'b0;
        q    = '0;

        if (s_tuser)
        begin
            mode_next  = pcss_pkg::MODE_NONE;
            sopen_next = 1'b0;
            dopen_next = 1'b0;
            srun_next  = 2'd0;
            drun_next  = 2'd0;
            esc_next   = 1'b0;
            cmt_next   = 1'b0;
            blank_next = 2'd0;
            prev_next  = 8'd0;
            lnl_next   = 1'b0;
        end
        else
        begin
            mode_next  = mode_reg;
            sopen_next = sopen_reg;
            dopen_next = dopen_reg;
            srun_next  = srun_reg;
            drun_next  = drun_reg;
            esc_next   = esc_reg;
            cmt_next   = cmt_reg;
            blank_next = blank_reg;
            prev_next  = prev_reg;
            lnl_next   = lnl_reg;
        end

        if (!cmt_next && !sopen_next && !dopen_next && mode_next == pcss_pkg::MODE_NONE
            && !esc_next && c == pcss_pkg::CH_HASH)
        begin
            cmt_next   = 1'b1;
            blank_next = 2'd0;
            prev_next  = c;
        end
        else if (cmt_next && c != pcss_pkg::CH_NL)
        begin
            prev_next = c;
        end
        else
        begin
            if (c == pcss_pkg::CH_NL)
            begin
                drop       = lnl_next;
                cmt_next   = 1'b0;
                blank_next = 2'd0;
            end
            else if (c == pcss_pkg::CH_DOUBLE)
            begin
                if (mode_next != pcss_pkg::MODE_SINGLE)
                begin
                    q = quote_step(drun_next, dopen_next, sopen_next,
                                   prev_next == pcss_pkg::CH_DOUBLE,
                                   pcss_pkg::MODE_DOUBLE, mode_next, cmt_next, esc_next);
                    drun_next  = q.run;
                    dopen_next = q.own_open;
                    sopen_next = q.other_open;
                    mode_next  = q.mode;
                    drop       = q.drop;
                end
                blank_next = 2'd0;
            end
            else if (c == pcss_pkg::CH_SINGLE)
            begin
                if (mode_next != pcss_pkg::MODE_DOUBLE)
                begin
                    q = quote_step(srun_next, sopen_next, dopen_next,
                                   prev_next == pcss_pkg::CH_SINGLE,
                                   pcss_pkg::MODE_SINGLE, mode_next, cmt_next, esc_next);
                    srun_next  = q.run;
                    sopen_next = q.own_open;
                    dopen_next = q.other_open;
                    mode_next  = q.mode;
                    drop       = q.drop;
                end
                blank_next = 2'd0;
            end
            else if (c == pcss_pkg::CH_TAB || c == pcss_pkg::CH_SPACE)
            begin
                if (lnl_next)
                    drop = 1'b1;
                else if (blank_next < pcss_pkg::BLANK_MAX)
                    blank_next = blank_next + 2'd1;
            end
            else
            begin
                blank_next = 2'd0;
            end

            if (mode_next == pcss_pkg::MODE_SINGLE)
            begin
                if (srun_next < pcss_pkg::RUN_FULL && c != pcss_pkg::CH_SINGLE)
                    srun_next = pcss_pkg::RUN_FULL;
                drun_next = 2'd0;
            end
            else if (mode_next == pcss_pkg::MODE_DOUBLE)
            begin
                if (drun_next < pcss_pkg::RUN_FULL && c != pcss_pkg::CH_DOUBLE)
                    drun_next = pcss_pkg::RUN_FULL;
                srun_next = 2'd0;
            end
            else
            begin
                if (c != pcss_pkg::CH_SINGLE)
                    srun_next = 2'd0;
                if (c != pcss_pkg::CH_DOUBLE)
                    drun_next = 2'd0;
            end

            if (!drop && !sopen_next && !dopen_next && mode_next == pcss_pkg::MODE_NONE
                && blank_next < pcss_pkg::BLANK_MAX)
            begin
                keep     = 1'b1;
                lnl_next = (c == pcss_pkg::CH_NL);
            end

            esc_next  = (c == pcss_pkg::CH_BSL) ? !esc_next : 1'b0;
            prev_next = c;
        end
    end

    always_comb
    begin
        if (accept)
            ovalid_next = keep;
        else if (m_tready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= pcss_pkg::MODE_NONE;
            sopen_reg  <= 1'b0;
            dopen_reg  <= 1'b0;
            srun_reg   <= 2'd0;
            drun_reg   <= 2'd0;
            esc_reg    <= 1'b0;
            cmt_reg    <= 1'b0;
            blank_reg  <= 2'd0;
            prev_reg   <= 8'd0;
            lnl_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            if (accept)
            begin
                mode_reg  <= mode_next;
                sopen_reg <= sopen_next;
                dopen_reg <= dopen_next;
                srun_reg  <= srun_next;
                drun_reg  <= drun_next;
                esc_reg   <= esc_next;
                cmt_reg   <= cmt_next;
                blank_reg <= blank_next;
                prev_reg  <= prev_next;
                lnl_reg   <= lnl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
            odata_reg <= s_tdata;
    end

endmodule

/* design/pcss_checker.sv */
// ----------------------------------------------------------------------------
// pcss_checker
// Port-level checks for the Python comment/string stripper.
// ----------------------------------------------------------------------------
`include "python_comment_string_stripper_core_defines.svh"

module pcss_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // stalled output beat holds
    `PCSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")

    // a full, stalled output register blocks the input
    `PCSS_ASSERT_NOW(a_in_blocked, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")

    // '#' on a start beat opens a comment: nothing comes out
    `PCSS_ASSERT_NEXT(a_hash_start, s_tvalid && s_tready && s_tuser && s_tdata == pcss_pkg::CH_HASH && (!m_tvalid || m_tready), !m_tvalid, "hash at start of text passed on")

    // quote bytes never reach the output
    `PCSS_ASSERT_NOW(a_no_quote, m_tvalid, m_tdata != pcss_pkg::CH_SINGLE && m_tdata != pcss_pkg::CH_DOUBLE, "quote byte passed on")

endmodule

bind python_comment_string_stripper_core pcss_checker u_pcss_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/stripper_checker.sv */
// ----------------------------------------------------------------------------
// stripper_checker
// Follows both channels of the Python stripper, works out which source bytes
// ought to survive and compares them in order with the kept-byte stream.
// ----------------------------------------------------------------------------
module stripper_checker
    import pcss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_char
    input  logic       s_tuser,   // [0] start_of_text
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] kept_char
    output int         fails,
    output int         bytes_due,
    output int         kept_count
);

    doc_mode_t  doc_mode      = MODE_NONE;
    logic       in_single     = 1'b0;
    logic       in_double     = 1'b0;
    logic [1:0] single_quotes = 2'd0;
    logic [1:0] double_quotes = 2'd0;
    logic       escaped       = 1'b0;
    logic       in_comment    = 1'b0;
    logic [1:0] blanks        = 2'd0;
    logic [7:0] prev_byte     = 8'h00;
    logic       newline_sent  = 1'b0;

    logic [7:0] kept_bytes_due[$];

    task automatic clear_scan();
        doc_mode      = MODE_NONE;
        in_single     = 1'b0;
        in_double     = 1'b0;
        single_quotes = 2'd0;
        double_quotes = 2'd0;
        escaped       = 1'b0;
        in_comment    = 1'b0;
        blanks        = 2'd0;
        prev_byte     = 8'h00;
        newline_sent  = 1'b0;
    endtask

    function automatic bit quoted();
        return in_single || in_double || (doc_mode != MODE_NONE);
    endfunction

    // one quote byte of kind qch; the other kind's open flag rides along
    function automatic quote_res_t quote_step(logic [1:0] run, logic own_open,
                                              logic other_open, logic [7:0] qch,
                                              doc_mode_t own_mode);
        quote_res_t r;
        r.run        = run;
        r.own_open   = own_open;
        r.other_open = other_open;
        r.mode       = doc_mode;
        r.drop       = 1'b0;
        if (doc_mode != MODE_NONE)
        begin
            if (run == RUN_FULL || prev_byte == qch)
                r.run = run - 2'd1;
            else
                r.run = RUN_FULL;
            r.mode = (r.run != 2'd0) ? own_mode : MODE_NONE;
            if (r.mode == MODE_NONE)
                r.drop = 1'b1;
        end
        else
        begin
            if (run == 2'd0 && !(own_open || other_open))
                r.run = run + 2'd1;
            else if (prev_byte == qch)
                r.run = run + 2'd1;
            r.mode = (r.run == RUN_FULL) ? own_mode : MODE_NONE;
            if (r.mode != MODE_NONE)
            begin
                r.own_open   = 1'b0;
                r.other_open = 1'b0;
                r.drop       = 1'b1;
            end
            else if (!other_open && !in_comment)
            begin
                if (own_open)
                begin
                    if (!escaped)
                    begin
                        r.own_open = 1'b0;
                        r.drop     = 1'b1;
                    end
                end
                else
                    r.own_open = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic scan_byte(input logic sot, input logic [7:0] c, output logic keep);
        quote_res_t q;
        logic       drop;
        keep = 1'b0;
        drop = 1'b0;
        if (sot)
            clear_scan();

        if (!in_comment && !quoted() && !escaped && c == CH_HASH)
        begin
            in_comment = 1'b1;
            blanks     = 2'd0;
            prev_byte  = c;
            return;
        end
        if (in_comment && c != CH_NL)
        begin
            prev_byte = c;
            return;
        end

        if (c == CH_NL)
        begin
            drop       = newline_sent;
            in_comment = 1'b0;
            blanks     = 2'd0;
        end
        else if (c == CH_DOUBLE)
        begin
            if (doc_mode != MODE_SINGLE)
            begin
                q = quote_step(double_quotes, in_double, in_single, CH_DOUBLE, MODE_DOUBLE);
                double_quotes = q.run;
                in_double     = q.own_open;
                in_single     = q.other_open;
                doc_mode      = q.mode;
                drop          = q.drop;
            end
            blanks = 2'd0;
        end
        else if (c == CH_SINGLE)
        begin
            if (doc_mode != MODE_DOUBLE)
            begin
                q = quote_step(single_quotes, in_single, in_double, CH_SINGLE, MODE_SINGLE);
                single_quotes = q.run;
                in_single     = q.own_open;
                in_double     = q.other_open;
                doc_mode      = q.mode;
                drop          = q.drop;
            end
            blanks = 2'd0;
        end
        else if (c == CH_TAB || c == CH_SPACE)
        begin
            if (newline_sent)
                drop = 1'b1;
            else if (blanks < BLANK_MAX)
                blanks = blanks + 2'd1;
        end
        else
            blanks = 2'd0;

        if (doc_mode == MODE_SINGLE)
        begin
            if (single_quotes < RUN_FULL && c != CH_SINGLE)
                single_quotes = RUN_FULL;
            double_quotes = 2'd0;
        end
        else if (doc_mode == MODE_DOUBLE)
        begin
            if (double_quotes < RUN_FULL && c != CH_DOUBLE)
                double_quotes = RUN_FULL;
            single_quotes = 2'd0;
        end
        else
        begin
            if (single_quotes != 2'd0 && c != CH_SINGLE)
                single_quotes = 2'd0;
            if (double_quotes != 2'd0 && c != CH_DOUBLE)
                double_quotes = 2'd0;
        end

        if (!drop && !quoted() && blanks < BLANK_MAX)
        begin
            keep         = 1'b1;
            newline_sent = (c == CH_NL);
        end

        escaped   = (c == CH_BSL) ? !escaped : 1'b0;
        prev_byte = c;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic       keep;
        logic [7:0] want;
        if (!rst_n)
        begin
            clear_scan();
            kept_bytes_due.delete();
            fails      = 0;
            kept_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                scan_byte(s_tuser, s_tdata, keep);
                if (keep)
                    kept_bytes_due.push_back(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                if (kept_bytes_due.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("kept byte %02h with nothing due", m_tdata);
                end
                else
                begin
                    want = kept_bytes_due.pop_front();
                    kept_count++;
                    if (m_tdata !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("kept byte mismatch: expected %02h, got %02h",
                                     want, m_tdata);
                    end
                end
            end
        end
        bytes_due = kept_bytes_due.size();
    end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Feeds Python-like source through the stripper with random gaps and stalls
// on both sides; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import pcss_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_BYTES = 550;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    int fails;
    int bytes_due;
    int kept_count;
    int bytes_sent  = 0;
    int starts_sent = 0;
    int cycle       = 0;
    bit steady      = 1'b0;
    bit hold_req    = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    python_comment_string_stripper_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stripper_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fails      (fails),
        .bytes_due  (bytes_due),
        .kept_count (kept_count)
    );

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles, %0d kept bytes still due",
                     cycle, bytes_due);
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < 15);
    endfunction

    // sink side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= !idle_now();
        end
    end

    task automatic send_byte(input logic sot, input logic [7:0] c);
        while (idle_now())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= sot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        if (sot)
            starts_sent++;
    endtask

    task automatic send_text(input string s, input bit first_start);
        for (int i = 0; i < s.len(); i++)
            send_byte(first_start && i == 0, s[i]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (bytes_due != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] body_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return 8'(8'h61 + $urandom_range(25));
        else if (pick < 75)
            return CH_SPACE;
        else if (pick < 85)
            return CH_HASH;
        else if (pick < 92)
            return (pick[0]) ? CH_SINGLE : CH_DOUBLE;
        else
            return 8'($urandom_range(255));
    endfunction

    task automatic random_token();
        int         kind;
        int         n;
        logic [7:0] q;
        logic [7:0] b;
        kind = $urandom_range(99);
        n    = $urandom_range(1, 6);
        q    = ($urandom_range(1) == 1) ? CH_SINGLE : CH_DOUBLE;
        if (kind < 25)
        begin
            repeat (n) send_byte(1'b0, ($urandom_range(4) == 0) ?
                                 8'(8'h28 + $urandom_range(21)) :
                                 8'(8'h61 + $urandom_range(25)));
        end
        else if (kind < 40)
        begin
            repeat (n) send_byte(1'b0, ($urandom_range(1) == 1) ? CH_SPACE : CH_TAB);
        end
        else if (kind < 50)
        begin
            repeat ($urandom_range(1, 2)) send_byte(1'b0, CH_NL);
        end
        else if (kind < 60)
        begin
            send_byte(1'b0, CH_HASH);
            repeat (n)
            begin
                b = body_byte();
                send_byte(1'b0, (b == CH_NL) ? CH_BSL : b);
            end
            send_byte(1'b0, CH_NL);
        end
        else if (kind < 78)
        begin
            send_byte(1'b0, q);
            repeat (n)
            begin
                if ($urandom_range(5) == 0)
                begin
                    send_byte(1'b0, CH_BSL);
                    send_byte(1'b0, ($urandom_range(1) == 1) ? q : CH_BSL);
                end
                else
                begin
                    b = body_byte();
                    send_byte(1'b0, (b == q) ? CH_SPACE : b);
                end
            end
            send_byte(1'b0, q);
        end
        else if (kind < 88)
        begin
            repeat (3) send_byte(1'b0, q);
            repeat (n)
            begin
                b = body_byte();
                send_byte(1'b0, ($urandom_range(4) == 0) ? CH_NL : b);
            end
            repeat (3) send_byte(1'b0, q);
        end
        else
        begin
            repeat (n) send_byte($urandom_range(99) == 0, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        int target;
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leading blanks, blank squeeze, repeated newline
        send_text(" \tx  \n\n", 1'b1);
        send_text("#\\'\n", 1'b0);
        send_text("'\\''", 1'b0);
        send_text("\"\"\"'\"\"\"", 1'b0);
        send_text("'#'", 1'b0);
        send_byte(1'b1, 8'h00);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, CH_NL);
        drain();

        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            steady = (bytes_sent > target - 300) && (bytes_sent < target - 200);
            if (!held && bytes_sent > target - 400)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && bytes_sent > target - 120)
            begin
                paused = 1'b1;
                drain();
            end
            random_token();
        end
        steady = 1'b0;

        drain();
        repeat (8) @(posedge clk);
        $display("%0d source bytes sent (%0d carrying a start flag), %0d kept bytes checked",
                 bytes_sent, starts_sent, kept_count);
        $display("comments, strings, docstrings, escapes and blank squeezing under stalls");
        if (fails == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* python_comment_string_stripper_core.f */
+incdir+design
design/pcss_pkg.sv
design/python_comment_string_stripper_core.sv
design/pcss_checker.sv
tb/stripper_checker.sv
tb/testbench.sv
